[rtl/core/multitouch_slot_event_decoder_defines.svh]
// Assertion macros shared by the decoder RTL.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef MULTITOUCH_SLOT_EVENT_DECODER_DEFINES_SVH
`define MULTITOUCH_SLOT_EVENT_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define MTSD_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("mtsd: invariant violated");
`define MTSD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mtsd: implication violated");
`else
`define MTSD_ASSERT(label, prop)
`define MTSD_ASSERT_IMPL(label, ante, cons)
`endif
`endif

[rtl/core/mtsd_pkg.sv]
`timescale 1ns / 1ps
package mtsd_pkg;

	localparam int VALUE_BITS     = 32;
	localparam int SCREEN_BITS    = 13;
	localparam int REQ_BITS       = 3;
	localparam int KIND_BITS      = 3;
	localparam int REG_IDX_BITS   = 3;
	localparam int FINGERS_DEF    = 5;
	localparam int COORD_BITS_DEF = 12;

	localparam logic signed [VALUE_BITS-1:0] X_MIN_RESET = 32'sd0;
	localparam logic signed [VALUE_BITS-1:0] X_MAX_RESET = 32'sd4095;
	localparam logic signed [VALUE_BITS-1:0] Y_MIN_RESET = 32'sd0;
	localparam logic signed [VALUE_BITS-1:0] Y_MAX_RESET = 32'sd4095;
	localparam logic [SCREEN_BITS-1:0] WIDTH_RESET  = 13'd800;
	localparam logic [SCREEN_BITS-1:0] HEIGHT_RESET = 13'd480;

	// Tracking id that marks a lifted finger (-1).
	localparam logic signed [VALUE_BITS-1:0] TRACK_ID_RELEASE = -32'sd1;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_SLOT  = 3'd0,
		REQ_TRACK = 3'd1,
		REQ_POS_X = 3'd2,
		REQ_POS_Y = 3'd3,
		REQ_SYNC  = 3'd4,
		REQ_OTHER = 3'd5
	} req_t;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_NONE    = 3'd0,
		KIND_PRESS   = 3'd1,
		KIND_MOVE    = 3'd2,
		KIND_RELEASE = 3'd3,
		KIND_ERROR   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PEND_NONE  = 2'd0,
		PEND_PRESS = 2'd1,
		PEND_MOVE  = 2'd2
	} pend_t;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_X_MIN    = 3'd0,
		REG_X_MAX    = 3'd1,
		REG_Y_MIN    = 3'd2,
		REG_Y_MAX    = 3'd3,
		REG_SCREEN_W = 3'd4,
		REG_SCREEN_H = 3'd5
	} cfg_reg_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_LOOK,
		T_SCALE,
		T_EMIT
	} top_state_t;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_MUL,
		SC_INIT,
		SC_ITER,
		SC_FIN
	} sc_state_t;

	// Request to the coordinate scaler. The value and range fields must
	// stay stable until the scaler reports done.
	typedef struct packed {
		logic                          start;
		logic signed [VALUE_BITS-1:0]  value;
		logic signed [VALUE_BITS-1:0]  lo;
		logic signed [VALUE_BITS-1:0]  hi;
		logic [SCREEN_BITS-1:0]        screen;
	} scale_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} scale_stat_t;

	function automatic kind_t pend_to_kind(input pend_t p);
		kind_t k;
		case (p)
			PEND_PRESS: k = KIND_PRESS;
			PEND_MOVE:  k = KIND_MOVE;
			default:    k = KIND_NONE;
		endcase
		return k;
	endfunction

endpackage

[rtl/core/mtsd_event_if.sv]
`timescale 1ns / 1ps
interface mtsd_event_if;
	logic                valid;
	logic                ready;
	logic [2:0]          req_type;
	logic signed [31:0]  event_value;
	logic                read_fault;

	modport source (output valid, req_type, event_value, read_fault, input ready);
	modport sink (input valid, req_type, event_value, read_fault, output ready);
endinterface

[rtl/core/mtsd_touch_if.sv]
`timescale 1ns / 1ps
interface mtsd_touch_if #(
	parameter int COORD_BITS = mtsd_pkg::COORD_BITS_DEF,
	parameter int SLOT_W     = 3
);
	logic                   valid;
	logic                   ready;
	logic [2:0]             touch_kind;
	logic [COORD_BITS-1:0]  screen_x;
	logic [COORD_BITS-1:0]  screen_y;
	logic [SLOT_W-1:0]      finger_index;

	modport source (output valid, touch_kind, screen_x, screen_y, finger_index, input ready);
	modport sink (input valid, touch_kind, screen_x, screen_y, finger_index, output ready);
endinterface

[rtl/core/mtsd_slot_mem.sv]
`timescale 1ns / 1ps
module mtsd_slot_mem #(
	parameter int DEPTH = mtsd_pkg::FINGERS_DEF,
	parameter int WIDTH = 2 * mtsd_pkg::COORD_BITS_DEF + 2,
	parameter int AW    = 3
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data
);
	import mtsd_pkg::*;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [WIDTH-1:0] rd_data_q;

	// Entries that were never written since reset read as all zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;
endmodule

[rtl/core/mtsd_scaler.sv]
`timescale 1ns / 1ps
module mtsd_scaler #(
	parameter int COORD_BITS = mtsd_pkg::COORD_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  mtsd_pkg::scale_cmd_t    cmd,
	output mtsd_pkg::scale_stat_t   stat,
	output logic [COORD_BITS-1:0]   result
);
	import mtsd_pkg::*;

	localparam int NUM_W = VALUE_BITS + SCREEN_BITS;
	localparam int CNT_W = $clog2(SCREEN_BITS + 1);
	localparam int CW    = (COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS;
	localparam logic [CW-1:0] CMAX = CW'((1 << COORD_BITS) - 1);

	sc_state_t state_q, state_d;

	logic [VALUE_BITS-1:0]  diff_q;
	logic [VALUE_BITS-1:0]  span_q;
	logic [SCREEN_BITS-1:0] outm1_q;
	logic                   zero_q;
	logic [NUM_W-1:0]       num_q;
	logic [VALUE_BITS-1:0]  rem_q;
	logic [SCREEN_BITS-1:0] nlow_q;
	logic [SCREEN_BITS-1:0] quo_q;
	logic                   sat_q;
	logic [CNT_W-1:0]       cnt_q;

	logic [VALUE_BITS:0]    trial;
	logic                   trial_ge;
	logic [SCREEN_BITS-1:0] q_sat;
	logic [SCREEN_BITS-1:0] q_lim;
	logic [CW-1:0]          q_wide;
	logic [CW-1:0]          q_clamp;

	// One restoring step: bring down the next numerator bit.
	assign trial    = {rem_q, nlow_q[SCREEN_BITS-1]};
	assign trial_ge = (trial >= {1'b0, span_q});

	// The quotient saturates when it would need more than SCREEN_BITS bits,
	// then it is limited to screen-1 and to the coordinate range.
	assign q_sat   = sat_q ? '1 : quo_q;
	assign q_lim   = (q_sat > outm1_q) ? outm1_q : q_sat;
	assign q_wide  = CW'(q_lim);
	assign q_clamp = zero_q ? '0 : ((q_wide > CMAX) ? CMAX : q_wide);
	assign result  = COORD_BITS'(q_clamp);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		stat.busy = (state_q != SC_IDLE);
		stat.done = 1'b0;
		case (state_q)
			SC_IDLE: begin
				if (cmd.start) state_d = SC_MUL;
			end
			SC_MUL:  state_d = SC_INIT;
			SC_INIT: state_d = SC_ITER;
			SC_ITER: begin
				if (cnt_q == CNT_W'(1)) state_d = SC_FIN;
			end
			SC_FIN: begin
				stat.done = 1'b1;
				state_d   = SC_IDLE;
			end
			default: state_d = SC_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SC_IDLE: begin
				diff_q  <= VALUE_BITS'(cmd.value - cmd.lo);
				span_q  <= VALUE_BITS'(cmd.hi - cmd.lo);
				outm1_q <= cmd.screen - SCREEN_BITS'(1);
				zero_q  <= (cmd.hi <= cmd.lo) || (cmd.screen == '0) || (cmd.value < cmd.lo);
			end
			SC_MUL: begin
				num_q <= NUM_W'(diff_q) * NUM_W'(outm1_q);
			end
			SC_INIT: begin
				rem_q  <= num_q[NUM_W-1:SCREEN_BITS];
				sat_q  <= (num_q[NUM_W-1:SCREEN_BITS] >= span_q);
				nlow_q <= num_q[SCREEN_BITS-1:0];
				quo_q  <= '0;
				cnt_q  <= CNT_W'(SCREEN_BITS);
			end
			SC_ITER: begin
				rem_q  <= trial_ge ? VALUE_BITS'(trial - {1'b0, span_q})
				                   : VALUE_BITS'(trial);
				quo_q  <= {quo_q[SCREEN_BITS-2:0], trial_ge};
				nlow_q <= {nlow_q[SCREEN_BITS-2:0], 1'b0};
				cnt_q  <= cnt_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
	end
endmodule

[rtl/core/multitouch_slot_event_decoder.sv]
`timescale 1ns / 1ps
// Slot, tracking id, sync, other and faulted items are decided in T_LOOK; position X or Y
// items also wait in T_SCALE for the 13-step coordinate divider before T_EMIT.
// One item at a time: the next item is accepted only after the result has been loaded
// into the output register, and T_EMIT holds while that register is still full.
// Reset: arst_n clears the slot table (valid bits), current slot and all control state;
// configuration registers return to their defaults. No clearing pass is needed.
module multitouch_slot_event_decoder #(
	parameter int FINGERS    = mtsd_pkg::FINGERS_DEF,
	parameter int COORD_BITS = mtsd_pkg::COORD_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mtsd_pkg::REG_IDX_BITS-1:0]  cfg_index,
	input  logic [mtsd_pkg::VALUE_BITS-1:0]    cfg_data,
	mtsd_event_if.sink                         evt,
	mtsd_touch_if.source                       touch
);
	import mtsd_pkg::*;

	// Slot number width and the layout of one slot entry: {pending, y, x}.
	localparam int SLOT_W = (FINGERS > 1) ? $clog2(FINGERS) : 1;
	localparam int EW     = 2 * COORD_BITS + 2;

	// Configuration registers.
	logic signed [VALUE_BITS-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [SCREEN_BITS-1:0]       width_q, height_q;

	// Control state.
	top_state_t state_q, state_d;
	logic [SLOT_W-1:0] cur_q;
	logic              cur_load;

	// The accepted item is held here until its result is produced.
	logic [REQ_BITS-1:0]          req_q;
	logic signed [VALUE_BITS-1:0] val_q;
	logic                         fault_q;

	// Result of the item in flight, then the output register.
	kind_t                 res_kind_q, res_kind_d;
	logic [COORD_BITS-1:0] res_x_q, res_x_d, res_y_q, res_y_d;
	logic [SLOT_W-1:0]     res_f_q, res_f_d;
	logic                  res_load;
	logic                  out_valid_q;
	kind_t                 out_kind_q;
	logic [COORD_BITS-1:0] out_x_q, out_y_q;
	logic [SLOT_W-1:0]     out_f_q;
	logic                  out_load;

	// Slot table port signals.
	logic              accept;
	logic [EW-1:0]     ent;
	logic [COORD_BITS-1:0] ent_x, ent_y;
	pend_t             ent_p;
	logic              mem_we;
	logic [EW-1:0]     mem_wdata;

	// Scaler.
	scale_cmd_t            sc_cmd;
	scale_stat_t           sc_stat;
	logic [COORD_BITS-1:0] sc_result;
	logic                  sc_start;
	logic                  is_x;
	logic                  slot_ok;
	pend_t                 pend_after_pos;

	// ---------------------------------------------------------------------------------
	// Configuration port. Writes must arrive only while the block is idle (the block does
	// not enforce this), so the scaler sees stable ranges for the whole of its computation.
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q  <= X_MIN_RESET;
			x_max_q  <= X_MAX_RESET;
			y_min_q  <= Y_MIN_RESET;
			y_max_q  <= Y_MAX_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_MIN:    x_min_q  <= cfg_data;
				REG_X_MAX:    x_max_q  <= cfg_data;
				REG_Y_MIN:    y_min_q  <= cfg_data;
				REG_Y_MAX:    y_max_q  <= cfg_data;
				REG_SCREEN_W: width_q  <= cfg_data[SCREEN_BITS-1:0];
				REG_SCREEN_H: height_q <= cfg_data[SCREEN_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------------------------------------------------------------------------
	// Slot table. The entry of the current slot is read at the accept edge and is
	// available in T_LOOK. Items are handled one at a time and every write lands before
	// the next accept, so a read never overlaps a write to the same entry.
	// ---------------------------------------------------------------------------------
	assign accept = evt.valid && evt.ready;

	mtsd_slot_mem #(
		.DEPTH (FINGERS),
		.WIDTH (EW),
		.AW    (SLOT_W)
	) u_slot_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (cur_q),
		.rd_data (ent),
		.wr_en   (mem_we),
		.wr_addr (cur_q),
		.wr_data (mem_wdata)
	);

	assign ent_x = ent[COORD_BITS-1:0];
	assign ent_y = ent[2*COORD_BITS-1:COORD_BITS];
	assign ent_p = pend_t'(ent[EW-1:2*COORD_BITS]);

	// ---------------------------------------------------------------------------------
	// Coordinate scaler: subtract, multiply, then a 13-step restoring division.
	// ---------------------------------------------------------------------------------
	assign is_x   = (req_t'(req_q) == REQ_POS_X);
	assign sc_cmd = '{
		start:  sc_start,
		value:  val_q,
		lo:     (is_x ? x_min_q : y_min_q),
		hi:     (is_x ? x_max_q : y_max_q),
		screen: (is_x ? width_q : height_q)
	};

	mtsd_scaler #(
		.COORD_BITS (COORD_BITS)
	) u_scaler (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (sc_cmd),
		.stat   (sc_stat),
		.result (sc_result)
	);

	// A slot select is taken only for 0 <= value < FINGERS.
	assign slot_ok = !val_q[VALUE_BITS-1] && (val_q < VALUE_BITS'(FINGERS));

	// A new position keeps a pending press; anything else becomes a move.
	assign pend_after_pos = (ent_p == PEND_PRESS) ? PEND_PRESS : PEND_MOVE;

	// ---------------------------------------------------------------------------------
	// Sequencer: T_IDLE takes an item, T_LOOK decides from the slot entry, T_SCALE
	// waits for the scaler and writes the new coordinate, T_EMIT moves the result into
	// the output register once it is free.
	// ---------------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		evt.ready    = 1'b0;
		mem_we       = 1'b0;
		mem_wdata    = ent;
		cur_load     = 1'b0;
		sc_start     = 1'b0;
		res_load     = 1'b0;
		res_kind_d   = KIND_NONE;
		res_x_d      = '0;
		res_y_d      = '0;
		res_f_d      = '0;
		out_load     = 1'b0;
		case (state_q)
			T_IDLE: begin
				evt.ready = 1'b1;
				if (evt.valid) state_d = T_LOOK;
			end
			T_LOOK: begin
				res_load = 1'b1;
				state_d  = T_EMIT;
				if (fault_q) begin
					// A failed read reports an error and leaves the state alone.
					res_kind_d = KIND_ERROR;
				end else begin
					case (req_t'(req_q))
						REQ_SLOT: begin
							if (slot_ok) begin
								cur_load = 1'b1;
								// Leaving a slot flushes its pending event.
								if (ent_p != PEND_NONE) begin
									mem_we     = 1'b1;
									mem_wdata  = {PEND_NONE, ent_y, ent_x};
									res_kind_d = pend_to_kind(ent_p);
									res_x_d    = ent_x;
									res_y_d    = ent_y;
									res_f_d    = cur_q;
								end
							end
						end
						REQ_TRACK: begin
							mem_we = 1'b1;
							if (val_q == TRACK_ID_RELEASE) begin
								mem_wdata  = {PEND_NONE, ent_y, ent_x};
								res_kind_d = KIND_RELEASE;
								res_x_d    = ent_x;
								res_y_d    = ent_y;
								res_f_d    = cur_q;
							end else begin
								mem_wdata = {PEND_PRESS, ent_y, ent_x};
							end
						end
						REQ_POS_X, REQ_POS_Y: begin
							sc_start = 1'b1;
							res_load = 1'b0;
							state_d  = T_SCALE;
						end
						REQ_SYNC: begin
							if (ent_p != PEND_NONE) begin
								mem_we     = 1'b1;
								mem_wdata  = {PEND_NONE, ent_y, ent_x};
								res_kind_d = pend_to_kind(ent_p);
								res_x_d    = ent_x;
								res_y_d    = ent_y;
								res_f_d    = cur_q;
							end
						end
						default: begin
						end
					endcase
				end
			end
			T_SCALE: begin
				if (sc_stat.done) begin
					mem_we    = 1'b1;
					mem_wdata = is_x ? {pend_after_pos, ent_y, sc_result}
					                 : {pend_after_pos, sc_result, ent_x};
					res_load  = 1'b1;
					state_d   = T_EMIT;
				end
			end
			T_EMIT: begin
				if (!out_valid_q || touch.ready) begin
					out_load = 1'b1;
					state_d  = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
		end else if (cur_load) begin
			cur_q <= SLOT_W'(val_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= evt.req_type;
			val_q   <= evt.event_value;
			fault_q <= evt.read_fault;
		end
		if (res_load) begin
			res_kind_q <= res_kind_d;
			res_x_q    <= res_x_d;
			res_y_q    <= res_y_d;
			res_f_q    <= res_f_d;
		end
		if (out_load) begin
			out_kind_q <= res_kind_q;
			out_x_q    <= res_x_q;
			out_y_q    <= res_y_q;
			out_f_q    <= res_f_q;
		end
	end

	// The output register holds a finished item until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (touch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign touch.valid        = out_valid_q;
	assign touch.touch_kind   = out_kind_q;
	assign touch.screen_x     = out_x_q;
	assign touch.screen_y     = out_y_q;
	assign touch.finger_index = out_f_q;

	// ---------------------------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------------------------
`include "multitouch_slot_event_decoder_defines.svh"

	`MTSD_ASSERT_IMPL(a_scaler_owned, sc_stat.busy, state_q == T_SCALE)
	`MTSD_ASSERT(a_cur_slot_range, 32'(cur_q) < FINGERS)
	`MTSD_ASSERT_IMPL(a_write_with_decision, mem_we, state_q == T_LOOK || (state_q == T_SCALE && sc_stat.done))
	`MTSD_ASSERT_IMPL(a_plain_result_zero, touch.valid && (touch.touch_kind == KIND_NONE || touch.touch_kind == KIND_ERROR), touch.screen_x == '0 && touch.screen_y == '0 && touch.finger_index == '0)

endmodule
